FILE: rtl/msc_pkg.sv
// Package for the snooping MOSI coherence controller.
// Holds sizes, command and request codes, the line state type and the structs
// shared between the top level and the transition logic. No dependencies.
`default_nettype none

package msc_pkg;

  localparam int LINES          = 256;
  localparam int LINE_BITS      = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int MODULE_ID_BITS = 4;

  localparam int CMD_W  = 3;
  localparam int LINE_W = 8;
  localparam int ID_W   = 4;
  localparam int REQ_W  = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STORE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GETS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GETM  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DATA  = 3'd4;

  localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GETS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GETM = 2'd2;

  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_O  = 3'd2,
    ST_M  = 3'd3,
    ST_IM = 3'd4,
    ST_IS = 3'd5,
    ST_SM = 3'd6,
    ST_OM = 3'd7
  } line_state_t;

  typedef logic [LINE_BITS-1:0]      line_addr_t;
  typedef logic [MODULE_ID_BITS-1:0] module_id_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    module_id_t       src;
    module_id_t       own_id;
    line_state_t      state;
    logic             in_range;
  } event_t;

  typedef struct packed {
    logic [REQ_W-1:0] bus_request;
    logic             supply_data;
    logic             data_to_processor;
    logic             shared_signal;
    logic             miss;
    logic             error;
  } action_t;

endpackage

`default_nettype wire

FILE: rtl/msc_in_if.sv
// Input channel of the coherence controller: one event word per handshake.
// Depends on msc_pkg for the field widths.
`default_nettype none

interface msc_in_if import msc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [LINE_W-1:0] line_index;
  logic [ID_W-1:0]   source_id;

  modport source (output valid, cmd, line_index, source_id, input ready);
  modport sink (input valid, cmd, line_index, source_id, output ready);
endinterface

`default_nettype wire

FILE: rtl/msc_out_if.sv
// Output channel of the coherence controller: one result word per handshake.
// Depends on msc_pkg for the field widths.
`default_nettype none

interface msc_out_if import msc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  bus_request;
  logic              supply_data;
  logic [ID_W-1:0]   data_target;
  logic              data_to_processor;
  logic              shared_signal;
  logic              miss;
  logic              error;
  logic [LINE_W-1:0] line_echo;

  modport source (output valid, bus_request, supply_data, data_target, data_to_processor,
                  shared_signal, miss, error, line_echo, input ready);
  modport sink (input valid, bus_request, supply_data, data_target, data_to_processor,
                shared_signal, miss, error, line_echo, output ready);
endinterface

`default_nettype wire

FILE: rtl/mosi_snoop_coherence_controller.sv
// Snooping MOSI coherence controller, top level.
// An accepted word is held in the lookup register (s1), and its result then in the output register.
// Throughput: one word per cycle while the output is not stalled; the line state memory is read at acceptance
// and written back when the word advances to the output register, with forwarding for back-to-back lines.
// Reset (rst, synchronous): all lines invalid, own_module_id zero, no words held.
`default_nettype none

module mosi_snoop_coherence_controller import msc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_write_en,
  input  wire logic [ID_W-1:0] cfg_write_data,
  msc_in_if.sink         in_ch,
  msc_out_if.source      out_ch
);

  logic [ID_W-1:0]   own_module_id;
  logic              s1_valid;
  logic [CMD_W-1:0]  s1_cmd;
  logic [LINE_W-1:0] s1_line;
  module_id_t        s1_src;
  logic              fwd_hit;
  line_state_t       fwd_state;
  logic              out_valid;
  action_t           out_action;
  logic [ID_W-1:0]   out_target;
  logic [LINE_W-1:0] out_line;

  logic        accept;
  logic        advance;
  line_state_t rd_state;
  event_t      ev;
  line_state_t next_state;
  action_t     action;
  logic        write_back;
  logic        wr_en;
  line_addr_t  wr_addr;

  assign accept  = in_ch.valid && in_ch.ready;
  assign advance = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  assign wr_en   = advance && write_back;
  assign wr_addr = LINE_BITS'(s1_line);

  msc_line_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (LINE_BITS'(in_ch.line_index)),
    .rd_data (rd_state),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (next_state)
  );

  always_comb begin
    ev.cmd      = s1_cmd;
    ev.src      = s1_src;
    ev.own_id   = MODULE_ID_BITS'(own_module_id);
    ev.state    = fwd_hit ? fwd_state : rd_state;
    ev.in_range = 32'(s1_line) < LINES;
  end

  msc_transition u_transition (
    .ev         (ev),
    .next_state (next_state),
    .action     (action),
    .write_back (write_back)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      own_module_id <= '0;
    end else if (cfg_write_en) begin
      own_module_id <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= wr_en && (wr_addr == LINE_BITS'(in_ch.line_index));
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd    <= in_ch.cmd;
      s1_line   <= in_ch.line_index;
      s1_src    <= MODULE_ID_BITS'(in_ch.source_id);
      fwd_state <= next_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action <= action;
      out_target <= action.supply_data ? ID_W'(s1_src) : '0;
      out_line   <= s1_line;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.bus_request       = out_action.bus_request;
  assign out_ch.supply_data       = out_action.supply_data;
  assign out_ch.data_target       = out_target;
  assign out_ch.data_to_processor = out_action.data_to_processor;
  assign out_ch.shared_signal     = out_action.shared_signal;
  assign out_ch.miss              = out_action.miss;
  assign out_ch.error             = out_action.error;
  assign out_ch.line_echo         = out_line;

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action.error |-> (out_action.bus_request == REQ_NONE) &&
      !out_action.supply_data && !out_action.shared_signal && !out_action.miss &&
      !out_action.data_to_processor)
    else $error("error result carries an action");

  a_miss_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action.miss |-> (out_action.bus_request != REQ_NONE))
    else $error("miss without a bus request");

  a_supply_shared: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action.supply_data |-> out_action.shared_signal)
    else $error("data supplied without the shared line");

  a_write_in_flight: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_valid && !out_action.error || s1_valid)
    else $error("state write without a word in flight");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word not held for lookup");

endmodule

`default_nettype wire

FILE: rtl/msc_line_store.sv
// Line state memory with one read and one write port and a registered read.
// Per-entry valid bits make unwritten lines read as invalid. Depends on msc_pkg.
`default_nettype none

module msc_line_store import msc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rd_en,
  input  wire line_addr_t  rd_addr,
  output line_state_t      rd_data,
  input  wire logic        wr_en,
  input  wire line_addr_t  wr_addr,
  input  wire line_state_t wr_data
);

  line_state_t mem [LINES];
  logic        written [LINES];
  line_state_t mem_q;
  logic        written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        written[i] <= 1'b0;
      end
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = written_q ? mem_q : ST_I;

endmodule

`default_nettype wire

FILE: rtl/msc_transition.sv
// MOSI transition logic: next line state and bus and processor actions for one
// event in a given state. Depends on msc_pkg.
`default_nettype none

module msc_transition import msc_pkg::*; (
  input  wire event_t ev,
  output line_state_t next_state,
  output action_t     action,
  output logic        write_back
);

  logic err;
  logic pending;
  logic held;

  assign pending = (ev.state == ST_IM) || (ev.state == ST_IS) ||
                   (ev.state == ST_SM) || (ev.state == ST_OM);
  assign held    = (ev.state == ST_S) || (ev.state == ST_O) || (ev.state == ST_M);

  always_comb begin
    err = 1'b0;
    case (ev.cmd)
      CMD_LOAD, CMD_STORE: err = pending;
      CMD_GETS, CMD_GETM:  err = 1'b0;
      CMD_DATA:            err = held;
      default:             err = 1'b1;
    endcase
    if (!ev.in_range) begin
      err = 1'b1;
    end
  end

  assign write_back = !err;

  always_comb begin
    next_state = ev.state;
    case (ev.cmd)
      CMD_LOAD, CMD_STORE: begin
        case (ev.state)
          ST_I:    next_state = (ev.cmd == CMD_LOAD) ? ST_IS : ST_IM;
          ST_S:    next_state = (ev.cmd == CMD_LOAD) ? ST_S : ST_SM;
          ST_O:    next_state = (ev.cmd == CMD_LOAD) ? ST_O : ST_OM;
          default: next_state = ev.state;
        endcase
      end
      CMD_GETS, CMD_GETM: begin
        case (ev.state)
          ST_S, ST_O: next_state = (ev.cmd == CMD_GETM) ? ST_I : ev.state;
          ST_M:       next_state = (ev.cmd == CMD_GETM) ? ST_I : ST_O;
          ST_SM:      next_state = (ev.cmd == CMD_GETM) ? ST_IM : ST_SM;
          ST_OM: begin
            if ((ev.cmd == CMD_GETM) && (ev.src != ev.own_id)) begin
              next_state = ST_IM;
            end
          end
          default: next_state = ev.state;
        endcase
      end
      CMD_DATA: begin
        case (ev.state)
          ST_IS:               next_state = ST_S;
          ST_IM, ST_SM, ST_OM: next_state = ST_M;
          default:             next_state = ev.state;
        endcase
      end
      default: next_state = ev.state;
    endcase
  end

  always_comb begin
    action = '0;
    case (ev.cmd)
      CMD_LOAD, CMD_STORE: begin
        case (ev.state)
          ST_I: begin
            action.bus_request = (ev.cmd == CMD_LOAD) ? REQ_GETS : REQ_GETM;
            action.miss        = 1'b1;
          end
          ST_S, ST_O: begin
            if (ev.cmd == CMD_LOAD) begin
              action.data_to_processor = 1'b1;
            end else begin
              action.bus_request = REQ_GETM;
              action.miss        = 1'b1;
            end
          end
          ST_M:    action.data_to_processor = 1'b1;
          default: action = '0;
        endcase
      end
      CMD_GETS, CMD_GETM: begin
        case (ev.state)
          ST_S, ST_SM: action.shared_signal = 1'b1;
          ST_O, ST_M, ST_OM: begin
            action.shared_signal = 1'b1;
            action.supply_data   = 1'b1;
          end
          default: action = '0;
        endcase
      end
      CMD_DATA: begin
        case (ev.state)
          ST_IS, ST_IM, ST_SM, ST_OM: action.data_to_processor = 1'b1;
          default:                    action = '0;
        endcase
      end
      default: action = '0;
    endcase
    if (err) begin
      action       = '0;
      action.error = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for mosi_snoop_coherence_controller: directed and random event words,
// checked against an in-bench MOSI line state predictor with random idling on both sides.
// Depends on msc_pkg, msc_in_if, msc_out_if and the controller RTL.
`timescale 1ns / 100ps

module tb_top;
  import msc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 350;

  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  bus_request;
    logic              supply_data;
    logic [ID_W-1:0]   data_target;
    logic              data_to_processor;
    logic              shared_signal;
    logic              miss;
    logic              error;
    logic [LINE_W-1:0] line_echo;
  } snoop_result_t;

  class coherence_scoreboard;
    line_state_t     line_st[LINES];
    logic [ID_W-1:0] own_id;
    snoop_result_t   awaited[$];
    int              fails;

    function new();
      foreach (line_st[i]) line_st[i] = ST_I;
      own_id = '0;
      fails = 0;
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] line,
                            logic [ID_W-1:0] src);
      line_state_t   st;
      line_state_t   nxt;
      snoop_result_t r;
      logic          getm;
      r = '0;
      r.line_echo = line;
      st = line_st[line];
      nxt = st;
      getm = (cmd == CMD_GETM);
      case (cmd)
        CMD_LOAD, CMD_STORE: begin
          case (st)
            ST_I: begin
              r.bus_request = (cmd == CMD_LOAD) ? REQ_GETS : REQ_GETM;
              nxt = (cmd == CMD_LOAD) ? ST_IS : ST_IM;
              r.miss = 1'b1;
            end
            ST_S, ST_O: begin
              if (cmd == CMD_LOAD) begin
                r.data_to_processor = 1'b1;
              end else begin
                r.bus_request = REQ_GETM;
                nxt = (st == ST_S) ? ST_SM : ST_OM;
                r.miss = 1'b1;
              end
            end
            ST_M: r.data_to_processor = 1'b1;
            default: r.error = 1'b1;
          endcase
        end
        CMD_GETS, CMD_GETM: begin
          case (st)
            ST_S: begin
              r.shared_signal = 1'b1;
              if (getm) nxt = ST_I;
            end
            ST_O: begin
              r.shared_signal = 1'b1;
              r.supply_data = 1'b1;
              if (getm) nxt = ST_I;
            end
            ST_M: begin
              r.shared_signal = 1'b1;
              r.supply_data = 1'b1;
              nxt = getm ? ST_I : ST_O;
            end
            ST_SM: begin
              r.shared_signal = 1'b1;
              if (getm) nxt = ST_IM;
            end
            ST_OM: begin
              r.shared_signal = 1'b1;
              r.supply_data = 1'b1;
              if (getm && src != own_id) nxt = ST_IM;
            end
            default: ;
          endcase
        end
        CMD_DATA: begin
          case (st)
            ST_S, ST_O, ST_M: r.error = 1'b1;
            ST_IS: begin
              r.data_to_processor = 1'b1;
              nxt = ST_S;
            end
            ST_IM, ST_SM, ST_OM: begin
              r.data_to_processor = 1'b1;
              nxt = ST_M;
            end
            default: ;
          endcase
        end
        default: r.error = 1'b1;
      endcase
      if (r.error) begin
        r = '0;
        r.error = 1'b1;
        r.line_echo = line;
      end else begin
        line_st[line] = nxt;
        if (r.supply_data) r.data_target = src;
      end
      awaited.push_back(r);
    endfunction

    function void check_word(snoop_result_t got);
      snoop_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word for line %0d", $realtime, got.line_echo);
        fails++;
      end else begin
        exp = awaited.pop_front();
        if (exp !== got) begin
          $display("%0t: exp req=%0d sup=%0d tgt=%0d proc=%0d shr=%0d miss=%0d err=%0d line=%0d",
                   $realtime, exp.bus_request, exp.supply_data, exp.data_target,
                   exp.data_to_processor, exp.shared_signal, exp.miss, exp.error, exp.line_echo);
          $display("%0t: act req=%0d sup=%0d tgt=%0d proc=%0d shr=%0d miss=%0d err=%0d line=%0d",
                   $realtime, got.bus_request, got.supply_data, got.data_target,
                   got.data_to_processor, got.shared_signal, got.miss, got.error, got.line_echo);
          fails++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [ID_W-1:0] cfg_write_data;
  logic calm;
  int   cycles;

  msc_in_if  in_bus ();
  msc_out_if out_bus ();

  coherence_scoreboard sb;

  mosi_snoop_coherence_controller dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (in_bus),
    .out_ch         (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL mosi_snoop_coherence_controller");
      $finish;
    end
  end

  initial begin
    calm <= 1'b0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin : ready_loop
      int gap;
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      sb.check_word({out_bus.bus_request, out_bus.supply_data, out_bus.data_target,
                     out_bus.data_to_processor, out_bus.shared_signal, out_bus.miss,
                     out_bus.error, out_bus.line_echo});
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] line,
                           logic [ID_W-1:0] src);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd <= cmd;
    in_bus.line_index <= line;
    in_bus.source_id <= src;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_word(cmd, line, src);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_id(logic [ID_W-1:0] id);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= id;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.own_id = id;
  endtask

  task automatic random_phase(int count);
    logic [LINE_W-1:0] hot_lines[8];
    logic [CMD_W-1:0]  cmd;
    logic [LINE_W-1:0] line;
    logic [ID_W-1:0]   src;
    line_state_t       st;
    int                n;
    hot_lines = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd127, 8'd128, 8'd254, 8'd255};
    n = 0;
    while (n < count) begin
      line = ($urandom_range(0, 99) < 70) ? hot_lines[$urandom_range(0, 7)]
                                          : 8'($urandom_range(0, 255));
      st = sb.line_st[line];
      if ($urandom_range(0, 99) < 15) begin
        cmd = 3'($urandom_range(0, 7));
      end else begin
        case (st)
          ST_I: cmd = 3'($urandom_range(CMD_LOAD, CMD_STORE));
          ST_IS, ST_IM, ST_SM, ST_OM:
            cmd = ($urandom_range(0, 99) < 50) ? CMD_DATA
                                                : 3'($urandom_range(CMD_GETS, CMD_GETM));
          default: cmd = 3'($urandom_range(CMD_LOAD, CMD_GETM));
        endcase
      end
      src = ($urandom_range(0, 99) < 35) ? sb.own_id : 4'($urandom_range(0, 15));
      if (!(st == ST_I && (cmd == CMD_GETS || cmd == CMD_GETM || cmd == CMD_DATA))) n++;
      send_word(cmd, line, src);
    end
  endtask

  initial begin
    sb = new();
    cycles <= 0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_bus.valid <= 1'b0;
    in_bus.cmd <= CMD_LOAD;
    in_bus.line_index <= '0;
    in_bus.source_id <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    send_word(CMD_LOAD, 8'd0, 4'd0);
    send_word(CMD_GETS, 8'd0, 4'd3);
    send_word(CMD_DATA, 8'd0, 4'd0);
    send_word(CMD_LOAD, 8'd0, 4'd0);
    send_word(CMD_GETS, 8'd0, 4'd4);
    send_word(CMD_STORE, 8'd0, 4'd0);
    send_word(CMD_LOAD, 8'd0, 4'd0);
    send_word(CMD_GETS, 8'd0, 4'd6);
    send_word(CMD_DATA, 8'd0, 4'd0);
    send_word(CMD_STORE, 8'd0, 4'd0);
    send_word(CMD_DATA, 8'd0, 4'd0);
    send_word(CMD_GETS, 8'd0, 4'd9);
    send_word(CMD_LOAD, 8'd0, 4'd0);
    send_word(CMD_DATA, 8'd0, 4'd0);
    send_word(CMD_STORE, 8'd0, 4'd0);
    send_word(CMD_GETM, 8'd0, 4'd0);
    send_word(CMD_GETM, 8'd0, 4'd15);
    send_word(CMD_STORE, 8'd0, 4'd0);
    send_word(CMD_DATA, 8'd0, 4'd0);
    send_word(CMD_GETM, 8'd0, 4'd5);
    send_word(CMD_STORE, 8'd255, 4'd0);
    send_word(CMD_DATA, 8'd255, 4'd10);
    send_word(CMD_RSVD_A, 8'd1, 4'd15);
    send_word(CMD_RSVD_B, 8'd2, 4'd0);
    send_word(CMD_RSVD_C, 8'd255, 4'd15);

    write_own_id(4'd15);
    random_phase(PHASE_WORDS);
    write_own_id(4'd0);
    random_phase(PHASE_WORDS);
    write_own_id(4'($urandom_range(1, 14)));
    random_phase(PHASE_WORDS);
    write_own_id(4'($urandom_range(0, 15)));
    random_phase(PHASE_WORDS);

    drain();
    repeat (8) @(posedge clk);
    if (sb.fails == 0) begin
      $display("PASS mosi_snoop_coherence_controller");
    end else begin
      $display("FAIL mosi_snoop_coherence_controller");
    end
    $finish;
  end

endmodule
